[design/unsigned_alu_add_sub_mul_div_assert.svh]
// ============================================================================
// Assertion macros
// Shared assertion macros for the unsigned ALU pipeline.
// ============================================================================
`ifndef UNSIGNED_ALU_ADD_SUB_MUL_DIV_ASSERT_SVH
`define UNSIGNED_ALU_ADD_SUB_MUL_DIV_ASSERT_SVH

// Implication checked only while the block is out of reset.
`define UALU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked also during reset.
`define UALU_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

[design/ualu_pkg.sv]
// ============================================================================
// ALU package
// Widths, operation codes and the pipeline stage type of the unsigned ALU.
// ============================================================================
`timescale 1ns / 1ps

package ualu_pkg;

    localparam int W     = 32;
    localparam int NSTEP = 2 * W;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef struct packed {
        logic           vld;
        cmd_t           cmd;
        logic           dz;
        logic [W-1:0]   dvs;
        logic [W-1:0]   rem;
        logic [W-1:0]   num;
        logic [2*W-1:0] acc;
    } pipe_t;

endpackage

[design/ualu_stage.sv]
// ============================================================================
// ALU divider stage
// One pipeline register that performs one restoring division step.
// ============================================================================
`timescale 1ns / 1ps

module ualu_stage
    import ualu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t d_in,
    output pipe_t d_out
);

    pipe_t        data_next;
    pipe_t        data_reg;
    logic         vld_reg;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;

    always_comb begin
        data_next = d_in;
        trial     = {d_in.rem, d_in.num[W-1]};
        diff      = trial - {1'b0, d_in.dvs};
        ge        = !diff[W];
        if (d_in.cmd == CMD_DIV && !d_in.dz) begin
            data_next.rem = ge ? diff[W-1:0] : trial[W-1:0];
            data_next.num = d_in.num << 1;
            data_next.acc = {d_in.acc[2*W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= d_in.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_comb begin
        d_out     = data_reg;
        d_out.vld = vld_reg;
    end

endmodule

[design/unsigned_alu_add_sub_mul_div.sv]
// ============================================================================
// Unsigned ALU
// Pipelined 32-bit add, subtract, multiply and fixed-point divide.
// ============================================================================
// The s_ channel carries one operation per transaction: s_tuser holds the
// operation code, s_tdata the two operands and the carry-in. The m_ channel
// returns exactly one result per transaction, in order: m_tdata holds the
// 64-bit result and m_tuser flags a divide by zero, in which case the result
// is all ones.
// Every operation passes through the same 65 register stages: an input stage
// that also forms sums, differences and products, followed by 64 stages that
// each compute one quotient bit of the restoring divider. One transaction is
// taken in every cycle while the pipeline is not held for m_tready.
// The pipeline moves as a whole. When the receiver holds m_tready low while
// a result is waiting, all stages hold and s_tready drops in the same cycle,
// even when earlier stages are empty.
// Reset clears all valid bits; no result is presented until new input.
// ============================================================================
`timescale 1ns / 1ps

module unsigned_alu_add_sub_mul_div
    import ualu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // operand_a, operand_b, cin, zero fill
    input  logic [1:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result
    output logic [0:0]   m_tuser    // div_by_zero
);

    pipe_t          stg [0:NSTEP];
    pipe_t          first_next;
    pipe_t          first_reg;
    logic           first_vld_reg;
    logic           en;
    cmd_t           cmd;
    logic [W-1:0]   op_a;
    logic [W-1:0]   op_b;
    logic [2*W-1:0] ext_a;
    logic [2*W-1:0] ext_b;
    logic [2*W-1:0] sum;
    logic [2*W-1:0] dif;
    logic [2*W-1:0] mask_w1;

    assign en       = !stg[NSTEP].vld || m_tready;
    assign s_tready = en;

    assign cmd     = cmd_t'(s_tuser);
    assign op_a    = s_tdata[W-1:0];
    assign op_b    = s_tdata[2*W-1:W];
    assign ext_a   = {{W{1'b0}}, op_a};
    assign ext_b   = {{W{1'b0}}, op_b};
    assign mask_w1 = ~({(2*W){1'b1}} << (W + 1));
    assign sum     = ext_a + ext_b + {{(2*W-1){1'b0}}, s_tdata[2*W]};
    assign dif     = (ext_a + {{W{1'b0}}, ~op_b} + {{(2*W-1){1'b0}}, 1'b1}) & mask_w1;

    always_comb begin
        first_next     = '0;
        first_next.vld = s_tvalid;
        first_next.cmd = cmd;
        first_next.dvs = op_b;
        first_next.num = op_a;
        case (cmd)
            CMD_ADD: first_next.acc = sum;
            CMD_SUB: first_next.acc = dif;
            CMD_MUL: first_next.acc = ext_a * ext_b;
            CMD_DIV: begin
                first_next.dz  = (op_b == '0);
                first_next.acc = (op_b == '0) ? {(2*W){1'b1}} : {(2*W){1'b0}};
            end
            default: first_next.acc = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_vld_reg <= 1'b0;
        end else if (en) begin
            first_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            first_reg <= first_next;
        end
    end

    always_comb begin
        stg[0]     = first_reg;
        stg[0].vld = first_vld_reg;
    end

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        ualu_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (stg[i]),
            .d_out   (stg[i+1])
        );
    end

    assign m_tvalid   = stg[NSTEP].vld;
    assign m_tdata    = stg[NSTEP].acc;
    assign m_tuser[0] = stg[NSTEP].dz;

`include "unsigned_alu_add_sub_mul_div_assert.svh"

    `UALU_ASSERT_IMP(a_dz_ones, m_tvalid && m_tuser[0], &m_tdata, "dz result not all ones")
    `UALU_ASSERT_IMP(a_dz_div, m_tvalid && m_tuser[0], stg[NSTEP].cmd == CMD_DIV, "bad dz")
    `UALU_ASSERT_RST(a_rst_empty, !aresetn, !m_tvalid, "result valid right after reset")

endmodule
